FILE: sv/kbmse_pkg.sv
`default_nettype none

package kbmse_pkg;

   localparam int unsigned ROW_COUNT = 9;

   localparam logic [3:0] FIRST_ROW      = 4'd0;
   localparam logic [3:0] LAST_ROW       = 4'd8;
   localparam logic [3:0] FIRST_HIGH_ROW = 4'd6;

   localparam logic OP_SCAN    = 1'b0;
   localparam logic OP_COMMAND = 1'b1;

   localparam logic [7:0] HIGH_ROW_BASE = 8'hC0;

   localparam logic [7:0] CMD_QUERY   = 8'h03;
   localparam logic [7:0] CMD_ECHO    = 8'h80;
   localparam logic [7:0] CODE_QUERY  = 8'h02;
   localparam logic [7:0] CODE_ECHO   = 8'h80;

   localparam logic [3:0] MOD_COMMAND = 4'd1;
   localparam logic [3:0] MOD_CTRL    = 4'd2;
   localparam logic [3:0] MOD_SHIFT_L = 4'd4;
   localparam logic [3:0] MOD_SHIFT_R = 4'd8;

   localparam logic [7:0] OFFSET_COMMAND = 8'h90;
   localparam logic [7:0] OFFSET_CTRL    = 8'h60;
   localparam logic [7:0] OFFSET_SHIFT   = 8'h30;
   localparam logic [7:0] OFFSET_NONE    = 8'h00;

   typedef struct packed {
      logic       op;
      logic [7:0] row_bits;
      logic [3:0] modifier_bits;
      logic [7:0] command_byte;
   } req_type;

   typedef struct packed {
      logic       key_valid;
      logic [7:0] key_code;
      logic [3:0] next_row;
   } rsp_type;

   function automatic logic [2:0] top_bit(input logic [7:0] v);
      logic [2:0] pos;
      pos = 3'd0;
      for (int b = 0; b < 8; b++) begin
         if (v[b]) begin
            pos = 3'(b);
         end
      end
      return pos;
   endfunction

   function automatic logic [7:0] modifier_offset(input logic [3:0] m);
      logic [7:0] off;
      unique case (m)
         MOD_COMMAND: off = OFFSET_COMMAND;
         MOD_CTRL:    off = OFFSET_CTRL;
         MOD_SHIFT_L: off = OFFSET_SHIFT;
         MOD_SHIFT_R: off = OFFSET_SHIFT;
         default:     off = OFFSET_NONE;
      endcase
      return off;
   endfunction

endpackage

`default_nettype wire

FILE: sv/kbmse_in_reg.sv
`default_nettype none

module kbmse_in_reg (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire kbmse_pkg::req_type req_data,
   output logic                   item_valid,
   output kbmse_pkg::req_type     item_data,
   input  wire logic              item_take
);

   logic               valid_ff;
   logic               valid_in;
   kbmse_pkg::req_type data_ff;
   logic               load;

   assign req_stall = valid_ff & ~item_take;
   assign load      = req_valid & ~req_stall;

   always_comb begin
      valid_in = (valid_ff & ~item_take) | load;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= req_data;
      end
   end

   assign item_valid = valid_ff;
   assign item_data  = data_ff;

endmodule

`default_nettype wire

FILE: sv/kbmse_scan_core.sv
`default_nettype none

module kbmse_scan_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              item_fire,
   input  wire kbmse_pkg::req_type item_data,
   output kbmse_pkg::rsp_type     result
);

   logic [7:0] row_mem_ff [kbmse_pkg::ROW_COUNT];
   logic [3:0] scan_index_ff;
   logic [3:0] scan_index_in;

   logic [3:0] row_sel;
   logic [3:0] row_next;
   logic [7:0] old_bits;
   logic [7:0] fresh;
   logic [2:0] col;
   logic [1:0] high_off;
   logic [7:0] base_code;
   logic [7:0] key_code;
   logic       key_valid;
   logic       is_scan;
   logic       row_changed;

   assign row_sel  = (scan_index_ff > kbmse_pkg::LAST_ROW) ? kbmse_pkg::FIRST_ROW
                                                           : scan_index_ff;
   assign row_next = (row_sel == kbmse_pkg::LAST_ROW) ? kbmse_pkg::FIRST_ROW
                                                      : row_sel + 4'd1;
   assign old_bits    = row_mem_ff[row_sel];
   assign row_changed = old_bits != item_data.row_bits;
   assign fresh       = ~old_bits & item_data.row_bits;
   assign col         = kbmse_pkg::top_bit(fresh);
   assign high_off    = 2'(row_sel - kbmse_pkg::FIRST_HIGH_ROW);
   assign is_scan     = item_data.op == kbmse_pkg::OP_SCAN;

   // high rows live in their own code block
   always_comb begin
      if (row_sel >= kbmse_pkg::FIRST_HIGH_ROW) begin
         base_code = kbmse_pkg::HIGH_ROW_BASE + {3'b000, high_off, col};
      end else begin
         base_code = {2'b00, row_sel[2:0], col};
      end
   end

   always_comb begin
      key_valid = 1'b0;
      key_code  = 8'h00;
      if (!is_scan) begin
         priority if (item_data.command_byte == kbmse_pkg::CMD_QUERY) begin
            key_valid = 1'b1;
            key_code  = kbmse_pkg::CODE_QUERY;
         end else if (item_data.command_byte == kbmse_pkg::CMD_ECHO) begin
            key_valid = 1'b1;
            key_code  = kbmse_pkg::CODE_ECHO;
         end else begin
            key_valid = 1'b0;
         end
      end else if (fresh != 8'h00) begin
         key_valid = 1'b1;
         key_code  = base_code + kbmse_pkg::modifier_offset(item_data.modifier_bits);
      end
   end

   always_comb begin
      scan_index_in = scan_index_ff;
      if (item_fire && is_scan) begin
         scan_index_in = row_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_index_ff <= kbmse_pkg::FIRST_ROW;
      end else begin
         scan_index_ff <= scan_index_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < kbmse_pkg::ROW_COUNT; r++) begin
            row_mem_ff[r] <= 8'h00;
         end
      end else if (item_fire && is_scan && row_changed) begin
         row_mem_ff[row_sel] <= item_data.row_bits;
      end
   end

   assign result.key_valid = key_valid;
   assign result.key_code  = key_code;
   assign result.next_row  = is_scan ? row_next : scan_index_ff;

endmodule

`default_nettype wire

FILE: sv/keyboard_matrix_scan_encoder_top.sv
// keyboard matrix scan encoder
// req channel: one beat per item; op selects a scan tick (row_bits and
//   modifier_bits of the row at the current scan index) or a host command
//   byte. the scan index walks rows 0 to 8 and wraps.
// rsp channel: exactly one beat per req beat, in order: key_valid and
//   key_code for a new key press or a command answer, and next_row, the row
//   the next scan tick will read.
// path: a req beat passes the input register, then the result register, on
//   its way to rsp; a stalled rsp holds it in the input register.
// throughput: one item per cycle while rsp is not stalled; the whole encode step is one pass of
//   logic between the input register and the result register.
// reset: clears the stored rows to all zeros, the scan index to row 0 and
//   both valid flags; the block takes beats in the first cycle after reset.
// rsp_stall: the result register holds its beat; the input register takes
//   one more beat if it is empty, then req_stall rises until rsp drains.
`default_nettype none

module keyboard_matrix_scan_encoder_top (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire kbmse_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output kbmse_pkg::rsp_type     rsp_data
);

   logic               item_valid;
   kbmse_pkg::req_type item_data;
   logic               advance;
   kbmse_pkg::rsp_type result;

   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   kbmse_pkg::rsp_type rsp_data_ff;

   assign advance = item_valid & (~rsp_valid_ff | ~rsp_stall);

   kbmse_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .item_valid (item_valid),
      .item_data  (item_data),
      .item_take  (advance)
   );

   kbmse_scan_core u_scan_core (
      .clock     (clock),
      .reset     (reset),
      .item_fire (advance),
      .item_data (item_data),
      .result    (result)
   );

   always_comb begin
      rsp_valid_in = advance | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire
